FILE: src/assert_macros.svh
// Assertion macros shared by the reply datagram parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/urdp_pkg.sv
// Shared types, constants and CRC-8 helpers for the reply datagram parser.
`default_nettype none

package urdp_pkg;

  // Window holds the seven bytes that precede the CRC byte.
  localparam int unsigned WIN_LEN   = 7;
  localparam logic [7:0]  CRC_POLY  = 8'h07;
  localparam logic [7:0]  MARK_BYTE = 8'hFF;
  localparam logic [7:0]  SYNC_RESET = 8'h05;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // Result of one processed beat, handed from the engine to the output register.
  typedef struct packed {
    logic        hit;
    logic        status;
    logic [31:0] data;
  } result_t;

  // Feed one byte into the CRC, least significant bit first.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ data[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // CRC contribution of a single set bit in the oldest byte of a full window.
  function automatic logic [7:0] drop_term(input int unsigned k);
    logic [7:0] c;
    c = crc8_feed(8'h00, 8'(32'd1 << k));
    for (int j = 0; j < WIN_LEN - 1; j++) begin
      c = crc8_feed(c, 8'h00);
    end
    return c;
  endfunction

  localparam logic [7:0] DROP_TERM [8] = '{
    drop_term(0), drop_term(1), drop_term(2), drop_term(3),
    drop_term(4), drop_term(5), drop_term(6), drop_term(7)
  };

  // The CRC is linear, so the oldest byte's share is an XOR of per-bit terms.
  function automatic logic [7:0] crc8_drop(input logic [7:0] oldest);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (oldest[k]) begin
        c = c ^ DROP_TERM[k];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/urdp_engine.sv
// Datagram window, running CRC and match logic of the reply datagram parser.
`default_nettype none

`include "assert_macros.svh"

module urdp_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             last_of_buffer,
  input  wire logic [7:0]       sync_byte,
  output urdp_pkg::result_t     res
);
  import urdp_pkg::*;

  logic [7:0] window [WIN_LEN];
  logic [2:0] fill_count;
  logic       discard_rest;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic       full;
  logic       candidate;
  logic       match;

  // A candidate datagram is the full window plus the incoming CRC byte.
  assign full      = (fill_count == 3'(WIN_LEN));
  assign candidate = !discard_rest && full &&
                     (window[0] == sync_byte) && (window[1] == MARK_BYTE);
  assign match     = (crc == rx_byte);

  always_comb begin
    res.hit    = candidate;
    res.status = match ? STATUS_OK : STATUS_CRC_ERR;
    res.data   = match ? {window[3], window[4], window[5], window[6]} : 32'h0;
  end

  // The running CRC always covers the bytes held in the window.
  always_comb begin
    if (full) begin
      crc_next = crc8_feed(crc ^ crc8_drop(window[0]), rx_byte);
    end else begin
      crc_next = crc8_feed(crc, rx_byte);
    end
  end

  // Control state: fill count, discard flag and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      discard_rest <= 1'b0;
      crc          <= '0;
    end else if (step) begin
      if (last_of_buffer) begin
        fill_count   <= '0;
        discard_rest <= 1'b0;
        crc          <= '0;
      end else if (!discard_rest) begin
        if (candidate && !match) begin
          discard_rest <= 1'b1;
        end else begin
          crc <= crc_next;
          if (!full) begin
            fill_count <= fill_count + 3'd1;
          end
        end
      end
    end
  end

  // Window bytes: fill in order, then slide by one byte per beat.
  always_ff @(posedge clk) begin
    if (step && !discard_rest && !(candidate && !match)) begin
      if (full) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          window[i] <= window[i + 1];
        end
        window[WIN_LEN - 1] <= rx_byte;
      end else begin
        window[fill_count] <= rx_byte;
      end
    end
  end

  `ASSERT_IMPLY(a_discard_needs_full, clk, rst, discard_rest, full)
  `ASSERT_NEXT(a_last_clears, clk, rst, step && last_of_buffer, fill_count == 3'd0 && !discard_rest)
  `ASSERT_NEXT(a_mismatch_discards, clk, rst, step && candidate && !match && !last_of_buffer, discard_rest)

endmodule

`default_nettype wire

FILE: src/uart_reply_datagram_parser.sv
// Top level of the UART reply datagram parser: input register, engine, result register.
//
// Usage: received bytes enter as beats on the input channel (in_valid/in_ready,
// rx_byte, last_of_buffer). Each beat is one byte of a receive buffer; the
// beat with last_of_buffer high closes the buffer and clears the window.
// A datagram is found when the seven buffered bytes start with sync_byte and
// 0xFF; the eighth byte is checked against their CRC-8. A match gives a
// result beat with status 0 and the big-endian register value in reg_value;
// a mismatch gives status 1 with reg_value zero and the rest of the buffer
// is dropped. Most bytes give no result beat.
// Throughput: one byte per cycle while no result is stalled, set by the update
// of the window and running CRC between the input and result registers.
// Reset: sync_byte returns to 0x05, the window empties and both registers go
// empty. cfg_wr_en/cfg_wr_data write sync_byte; the user must do so only while
// the block is idle, as the block itself does not enforce it. Stall: while
// out_ready is low a pending result holds; an empty input register still takes
// one more byte, then in_ready drops until the result is taken.
`default_nettype none

`include "assert_macros.svh"

module uart_reply_datagram_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        last_of_buffer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic [31:0]      reg_value
);
  import urdp_pkg::*;

  logic [7:0]  sync_val;
  logic        in_full;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        step;
  result_t     res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_val <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_val <= cfg_wr_data;
    end
  end

  // The held byte is processed once the result register can take a result.
  assign out_free = !out_valid || out_ready;
  assign step     = in_full && out_free;
  assign in_ready = !in_full || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
      in_last <= last_of_buffer;
    end
  end

  urdp_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_byte        (in_byte),
    .last_of_buffer (in_last),
    .sync_byte      (sync_val),
    .res            (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.hit) begin
      status    <= res.status;
      reg_value <= res.data;
    end
  end

  `ASSERT_IMPLY(a_err_no_data, clk, rst, out_valid && status == STATUS_CRC_ERR, reg_value == 32'h0)
  `ASSERT_NEXT(a_held_byte_kept, clk, rst, in_full && !out_free, in_full)
  `ASSERT_NEXT(a_stalled_result_kept, clk, rst, out_valid && !out_ready, out_valid)

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the UART reply datagram parser: directed table, random buffers, CRC predictor.
module tb_top;
  import urdp_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 290;
  localparam int NUM_PHASES    = 6;

  // How the byte of a directed row is formed.
  typedef enum logic [1:0] {
    BYTE_LIT,
    BYTE_CRC_GOOD,
    BYTE_CRC_BAD
  } byte_kind_t;

  typedef struct packed {
    logic        st;
    logic [31:0] data;
  } reply_t;

  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic        has_res;
    logic        st;
    logic [31:0] data;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        last_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        status;
  logic [31:0] reg_value;

  // Predictor state: window bytes with byte k at bits [8k+7:8k].
  logic [55:0] win_q = '0;
  int          fill_count = 0;
  logic        discard_rest = 1'b0;
  logic [7:0]  sync_q = SYNC_RESET;

  reply_t expected_replies[$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     burst_left = 0;
  int     hold_asks = 0;
  row_t   dir_rows [24];

  uart_reply_datagram_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .last_of_buffer (last_of_buffer),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .reg_value      (reg_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // CRC-8, polynomial 0x07, zero start, each byte fed LSB first.
  function automatic logic [7:0] window_crc(input logic [55:0] w);
    logic [7:0] crc;
    logic [7:0] cur;
    crc = 8'h00;
    for (int k = 0; k < 7; k++) begin
      cur = w[8*k +: 8];
      for (int i = 0; i < 8; i++) begin
        if (crc[7] ^ cur[i]) begin
          crc = {crc[6:0], 1'b0} ^ CRC_POLY;
        end else begin
          crc = {crc[6:0], 1'b0};
        end
      end
    end
    return crc;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte yields a reply.
  function automatic logic predict_reply(input logic [7:0] b, input logic l, output reply_t r);
    logic hit;
    hit = 1'b0;
    r = '0;
    if (!discard_rest) begin
      if (fill_count == 7) begin
        if (win_q[7:0] == sync_q && win_q[15:8] == MARK_BYTE) begin
          hit = 1'b1;
          if (window_crc(win_q) == b) begin
            r.st   = STATUS_OK;
            r.data = {win_q[31:24], win_q[39:32], win_q[47:40], win_q[55:48]};
          end else begin
            r.st   = STATUS_CRC_ERR;
            r.data = 32'd0;
            discard_rest = 1'b1;
          end
        end
        if (!discard_rest) begin
          win_q = {b, win_q[55:8]};
        end
      end else begin
        win_q[8*fill_count +: 8] = b;
        fill_count++;
      end
    end
    // The buffer end clears everything after the byte itself is handled.
    if (l) begin
      win_q = '0;
      fill_count = 0;
      discard_rest = 1'b0;
    end
    return hit;
  endfunction

  // Offers one beat, with bursts and random gaps, and returns once it is taken.
  task automatic offer_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    rx_byte        <= b;
    last_of_buffer <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic feed(input logic [7:0] b, input logic l);
    reply_t r;
    offer_byte(b, l);
    if (predict_reply(b, l, r)) begin
      expected_replies.push_back(r);
    end
  endtask

  // Waits until every reply is back and the pipeline has gone quiet.
  task automatic drain_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] v);
    drain_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sync_q = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Noise leans toward the two marker values so that near misses are common.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return sync_q;
      1: return MARK_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // One receive buffer: mostly datagrams among noise, sometimes noise alone.
  task automatic random_buffer();
    logic [7:0]  bytes[$];
    logic [55:0] dg;
    logic [7:0]  c;
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(0, 2)) bytes.push_back(noise_byte());
      repeat ($urandom_range(1, 3)) begin
        dg[7:0]  = sync_q;
        dg[15:8] = MARK_BYTE;
        for (int k = 2; k < 7; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            dg[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end else begin
            dg[8*k +: 8] = 8'($urandom);
          end
        end
        c = window_crc(dg);
        if ($urandom_range(0, 5) == 0) begin
          c = c ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < 7; k++) bytes.push_back(dg[8*k +: 8]);
        bytes.push_back(c);
      end
      repeat ($urandom_range(0, 3)) bytes.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 12)) bytes.push_back(noise_byte());
    end
    foreach (bytes[i]) begin
      feed(bytes[i], i == bytes.size() - 1);
    end
  endtask

  // Result side: checks each beat and stalls on its own changing pattern.
  initial begin : reply_sink
    int     pat_left;
    int     stall_pct;
    int     hold_left;
    int     holds_seen;
    reply_t want;
    pat_left = 0;
    stall_pct = 0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply with nothing expected: status %0d data %h",
                                    status, reg_value));
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.st) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
          end
          if (reg_value !== want.data) begin
            report_mismatch($sformatf("reg_value %h, expected %h", reg_value, want.data));
          end
        end
      end
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pat_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    logic       hit;
    reply_t     r;
    logic [7:0] sync_plan [NUM_PHASES];

    // Directed rows: short buffer, good datagram with all-ones data, then a CRC error
    // followed by two bytes that must be dropped.
    dir_rows = '{
      '{BYTE_LIT, SYNC_RESET, 1'b0, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, MARK_BYTE,  1'b0, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h01,      1'b0, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h02,      1'b0, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h03,      1'b1, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, SYNC_RESET, 1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, MARK_BYTE,  1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'hFF,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'hFF,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'hFF,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'hFF,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_CRC_GOOD, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_OK, 32'hFFFF_FFFF},
      '{BYTE_LIT, 8'h00,      1'b1, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, SYNC_RESET, 1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, MARK_BYTE,  1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b0, 1'b0, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_CRC_BAD, 8'h00,  1'b0, 1'b1, 1'b1, STATUS_CRC_ERR, 32'h0},
      '{BYTE_LIT, SYNC_RESET, 1'b0, 1'b1, 1'b0, STATUS_OK, 32'h0},
      '{BYTE_LIT, 8'h00,      1'b1, 1'b1, 1'b0, STATUS_OK, 32'h0}
    };
    sync_plan = '{8'h00, 8'hFF, 8'($urandom), SYNC_RESET, 8'($urandom), 8'hA5};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part; CRC bytes are derived from the current window.
    foreach (dir_rows[i]) begin
      b = dir_rows[i].b;
      if (dir_rows[i].kind != BYTE_LIT) begin
        b = window_crc(win_q) ^ ((dir_rows[i].kind == BYTE_CRC_BAD) ? 8'h01 : 8'h00);
      end
      offer_byte(b, dir_rows[i].l);
      hit = predict_reply(b, dir_rows[i].l, r);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].has_res) begin
          expected_replies.push_back(reply_t'{dir_rows[i].st, dir_rows[i].data});
        end
      end else if (hit) begin
        expected_replies.push_back(r);
      end
    end

    // Random phases, one sync value each; the second phase also fills the block.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_sync(sync_plan[p]);
      if (p == 1) begin
        hold_asks++;
      end
      while (items_sent < 24 + (p + 1) * PHASE_ITEMS) begin
        random_buffer();
      end
    end

    drain_idle();
    if (expected_replies.size() != 0) begin
      report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
